// ===== design/quad_corner_rotator_unit_defines.svh =====
// Assertion macros for the quad corner rotator.
// Used by quad_corner_rotator_unit.sv; needs clk_i and rst_ni in scope.
`ifndef QUAD_CORNER_ROTATOR_UNIT_DEFINES_SVH
`define QUAD_CORNER_ROTATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define QCR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define QCR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QCR_ASSERT(name, prop, msg)
`define QCR_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== design/qcr_pkg.sv =====
// Shared constants and elaboration-time functions for the quad corner rotator.
// No dependencies.
`timescale 1ns / 1ps

package qcr_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_CORNER0_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CORNER0_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CORNER1_X = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CORNER1_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CORNER2_X = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CORNER2_Y = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CORNER3_X = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_CORNER3_Y = 3'd7;

  // Input transaction kinds
  localparam logic KIND_SET    = 1'b0;
  localparam logic KIND_ROTATE = 1'b1;

  // Corner numbering
  localparam int CornerW = 2;
  localparam logic [CornerW-1:0] LastCorner = 2'd3;

  // Arctangent of 2^-i, 2^32 units per turn, rounded
  localparam int AtanLen = 24;
  localparam int AtanW   = 30;
  localparam logic [AtanW-1:0] ATAN_TABLE [AtanLen] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  // Squared CORDIC gain in Q30 after the given number of steps
  function automatic logic [63:0] cordic_gain_sq(input int steps);
    logic [63:0] p;
    p = 64'd1 << 30;
    for (int i = 0; i < steps; i++) begin
      p = p + (p >> (2 * i));
    end
    return p;
  endfunction

  // Integer square root, digit by digit
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem   = v;
    res   = 64'd0;
    bit_w = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

endpackage

// ===== design/quad_corner_rotator_unit.sv =====
// Quad corner rotator: four configured corners rotated about a pivot by a heading.
// Depends on qcr_pkg and quad_corner_rotator_unit_defines.svh.
//
// A set transaction (tuser = 0) loads the heading and leaves the sequencer idle.
// A rotate transaction (tuser = 1) adds its angle to the heading, then emits
// corners 0..3 rotated counterclockwise about the pivot, the last with tlast.
// One shared CORDIC add/shift unit and one 16 x 31 bit multiplier do all of
// the work under a sequencer, so a rotate transaction occupies the block
// from acceptance until its last corner enters the output register, which
// waits while the output is stalled; per corner that is CORDIC_STEPS
// iterations and, for x and for y, one multiplier pass per 16-bit digit of
// the magnitude for gain removal.
// s_axis_tready is high only while the sequencer is idle. Angles are binary,
// 2^ANGLE_WIDTH units per turn; results are rounded and saturated.
`timescale 1ns / 1ps
`include "quad_corner_rotator_unit_defines.svh"

module quad_corner_rotator_unit #(
  parameter int COORD_WIDTH  = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16,
  localparam int InDataW  = ((2 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OutDataW = ((2 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [qcr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]         cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [InDataW-1:0]             s_axis_tdata,   // pivot_x, pivot_y, angle_value
  input  logic [0:0]                     s_axis_tuser,   // kind
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OutDataW-1:0]            m_axis_tdata,   // rotated_x, rotated_y, heading_now
  output logic [qcr_pkg::CornerW-1:0]    m_axis_tuser,   // corner_index
  output logic                           m_axis_tlast    // last_corner
);

  import qcr_pkg::*;

  localparam int XW   = COORD_WIDTH + 20;        // CORDIC x/y, Q16 plus growth
  localparam int ZW   = 34;                      // residual angle, 2^32 per turn
  localparam int ND   = (XW + 15) / 16;          // multiplier digits per value
  localparam int MW   = 16 * ND;
  localparam int KW   = 31;
  localparam int ACCW = 16 * ND + KW;
  localparam int RW   = COORD_WIDTH + 4;
  localparam int IW   = $clog2(CORDIC_STEPS);
  localparam int DW   = $clog2(ND);

  // Gain compensation factor in Q30, worked out at elaboration
  localparam logic [63:0] GainSq   = cordic_gain_sq(CORDIC_STEPS);
  localparam logic [63:0] GainRoot = isqrt64(GainSq << 30);
  localparam logic [63:0] GainK    = (64'd1 << 60) / GainRoot;
  localparam logic [KW-1:0] KQ30   = GainK[KW-1:0];

  localparam logic [ACCW-1:0] RndHalf = ACCW'(64'd1 << 29);
  localparam logic signed [ANGLE_WIDTH-1:0] QuarterP =
    ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 2));
  localparam logic signed [ANGLE_WIDTH-1:0] QuarterN = -QuarterP;
  localparam logic signed [RW-1:0] SatHi = {5'b00000, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [RW-1:0] SatLo = ~SatHi;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_ABS,
    ST_MUL,
    ST_RND,
    ST_EMIT
  } state_e;

  state_e                         state_q;
  logic [ANGLE_WIDTH-1:0]         heading_q;
  logic signed [COORD_WIDTH-1:0]  cx_q [4];
  logic signed [COORD_WIDTH-1:0]  cy_q [4];
  logic signed [COORD_WIDTH-1:0]  px_q, py_q;
  logic [CornerW-1:0]             corner_q;
  logic [IW-1:0]                  iter_q;
  logic [DW-1:0]                  dig_q;
  logic                           sel_q;
  logic signed [XW-1:0]           x_q, y_q;
  logic signed [ZW-1:0]           z_q;
  logic [MW-1:0]                  mag_q;
  logic                           neg_q;
  logic [ACCW-1:0]                acc_q;
  logic [COORD_WIDTH-1:0]         rx_q, ry_q;
  logic                           m_valid_q;
  logic [CornerW-1:0]             m_corner_q;
  logic                           m_last_q;
  logic [COORD_WIDTH-1:0]         m_x_q, m_y_q;
  logic [ANGLE_WIDTH-1:0]         m_head_q;

  // Input unpacking
  logic                           in_kind;
  logic signed [COORD_WIDTH-1:0]  in_px, in_py;
  logic [ANGLE_WIDTH-1:0]         in_ang;
  logic                           s_fire;

  assign in_kind = s_axis_tuser[0];
  assign in_px   = s_axis_tdata[COORD_WIDTH-1:0];
  assign in_py   = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign in_ang  = s_axis_tdata[2*COORD_WIDTH+ANGLE_WIDTH-1:2*COORD_WIDTH];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Output register takes a new corner when it is empty or being drained
  logic                           emit_go;

  assign emit_go = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  // Corner setup: offset from pivot, half-turn fold into [-quarter, quarter]
  logic                           flip;
  logic signed [COORD_WIDTH:0]    dx, dy, dxf, dyf;
  logic [ANGLE_WIDTH-1:0]         a_adj;
  logic signed [XW-1:0]           x_ld, y_ld;
  logic signed [ZW-1:0]           z_ld;

  always_comb begin
    flip  = ($signed(heading_q) > QuarterP) || ($signed(heading_q) < QuarterN);
    dx    = (COORD_WIDTH + 1)'(cx_q[corner_q]) - (COORD_WIDTH + 1)'(px_q);
    dy    = (COORD_WIDTH + 1)'(cy_q[corner_q]) - (COORD_WIDTH + 1)'(py_q);
    dxf   = flip ? -dx : dx;
    dyf   = flip ? -dy : dy;
    a_adj = flip ? {~heading_q[ANGLE_WIDTH-1], heading_q[ANGLE_WIDTH-2:0]} : heading_q;
    x_ld  = {{(XW - COORD_WIDTH - 17){dxf[COORD_WIDTH]}}, dxf, 16'h0000};
    y_ld  = {{(XW - COORD_WIDTH - 17){dyf[COORD_WIDTH]}}, dyf, 16'h0000};
    z_ld  = {{(ZW - 32){a_adj[ANGLE_WIDTH-1]}}, a_adj, {(32 - ANGLE_WIDTH){1'b0}}};
  end

  // Shared CORDIC micro-rotation
  logic signed [XW-1:0]           xs, ys, x_it, y_it;
  logic signed [ZW-1:0]           atan_z, z_it;

  always_comb begin
    xs     = x_q >>> iter_q;
    ys     = y_q >>> iter_q;
    atan_z = $signed(ZW'(ATAN_TABLE[5'(iter_q)]));
    if (!z_q[ZW-1]) begin
      x_it = x_q - ys;
      y_it = y_q + xs;
      z_it = z_q - atan_z;
    end else begin
      x_it = x_q + ys;
      y_it = y_q - xs;
      z_it = z_q + atan_z;
    end
  end

  // Magnitude of the selected coordinate for gain removal
  logic signed [XW-1:0]           val, abs_val;

  always_comb begin
    val     = sel_q ? y_q : x_q;
    abs_val = val[XW-1] ? -val : val;
  end

  // One digit of the gain product per cycle; digit 0 enters floored by 2^16
  logic [15:0]                    digit;
  logic [16+KW-1:0]               prod;
  logic [ACCW+15:0]               prod_sh;
  logic [ACCW-1:0]                acc_mul;

  always_comb begin
    digit   = mag_q[{dig_q, 4'b0000} +: 16];
    prod    = (16 + KW)'(digit) * (16 + KW)'(KQ30);
    prod_sh = (ACCW + 16)'(prod) << {dig_q, 4'b0000};
    acc_mul = acc_q + prod_sh[ACCW+15:16];
  end

  // Round half away from zero, add pivot back, saturate
  logic [ACCW-1:0]                rnd_sum;
  logic [COORD_WIDTH+2:0]         m_mag;
  logic signed [RW-1:0]           m_signed, piv_ext, res_sum;
  logic [COORD_WIDTH-1:0]         sat_val;

  always_comb begin
    rnd_sum  = acc_q + RndHalf;
    m_mag    = rnd_sum[30 +: COORD_WIDTH + 3];
    m_signed = neg_q ? -$signed({1'b0, m_mag}) : $signed({1'b0, m_mag});
    piv_ext  = RW'(sel_q ? py_q : px_q);
    res_sum  = m_signed + piv_ext;
    if (res_sum > SatHi) begin
      sat_val = SatHi[COORD_WIDTH-1:0];
    end else if (res_sum < SatLo) begin
      sat_val = SatLo[COORD_WIDTH-1:0];
    end else begin
      sat_val = res_sum[COORD_WIDTH-1:0];
    end
  end

  // Sequencer, configuration registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      heading_q  <= '0;
      for (int c = 0; c < 4; c++) begin
        cx_q[c] <= '0;
        cy_q[c] <= '0;
      end
      px_q       <= '0;
      py_q       <= '0;
      corner_q   <= '0;
      iter_q     <= '0;
      dig_q      <= '0;
      sel_q      <= 1'b0;
      x_q        <= '0;
      y_q        <= '0;
      z_q        <= '0;
      mag_q      <= '0;
      neg_q      <= 1'b0;
      acc_q      <= '0;
      rx_q       <= '0;
      ry_q       <= '0;
      m_valid_q  <= 1'b0;
      m_corner_q <= '0;
      m_last_q   <= 1'b0;
      m_x_q      <= '0;
      m_y_q      <= '0;
      m_head_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CORNER0_X: cx_q[0] <= cfg_data_i;
          REG_CORNER0_Y: cy_q[0] <= cfg_data_i;
          REG_CORNER1_X: cx_q[1] <= cfg_data_i;
          REG_CORNER1_Y: cy_q[1] <= cfg_data_i;
          REG_CORNER2_X: cx_q[2] <= cfg_data_i;
          REG_CORNER2_Y: cy_q[2] <= cfg_data_i;
          REG_CORNER3_X: cx_q[3] <= cfg_data_i;
          REG_CORNER3_Y: cy_q[3] <= cfg_data_i;
          default: ;
        endcase
      end

      if (emit_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            if (in_kind == KIND_ROTATE) begin
              heading_q <= heading_q + in_ang;
              px_q      <= in_px;
              py_q      <= in_py;
              corner_q  <= '0;
              state_q   <= ST_LOAD;
            end else begin
              heading_q <= in_ang;
            end
          end
        end
        ST_LOAD: begin
          x_q     <= x_ld;
          y_q     <= y_ld;
          z_q     <= z_ld;
          iter_q  <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          x_q    <= x_it;
          y_q    <= y_it;
          z_q    <= z_it;
          iter_q <= iter_q + 1'b1;
          if (iter_q == IW'(CORDIC_STEPS - 1)) begin
            sel_q   <= 1'b0;
            state_q <= ST_ABS;
          end
        end
        ST_ABS: begin
          mag_q   <= MW'($unsigned(abs_val));
          neg_q   <= val[XW-1];
          acc_q   <= '0;
          dig_q   <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          acc_q <= acc_mul;
          dig_q <= dig_q + 1'b1;
          if (dig_q == DW'(ND - 1)) begin
            state_q <= ST_RND;
          end
        end
        ST_RND: begin
          if (!sel_q) begin
            rx_q    <= sat_val;
            sel_q   <= 1'b1;
            state_q <= ST_ABS;
          end else begin
            ry_q    <= sat_val;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            m_x_q      <= rx_q;
            m_y_q      <= ry_q;
            m_corner_q <= corner_q;
            m_last_q   <= (corner_q == LastCorner);
            m_head_q   <= heading_q;
            corner_q   <= corner_q + 1'b1;
            state_q    <= (corner_q == LastCorner) ? ST_IDLE : ST_LOAD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutDataW'({m_head_q, m_y_q, m_x_q});
  assign m_axis_tuser  = m_corner_q;
  assign m_axis_tlast  = m_last_q;

  // Checks
  `QCR_ASSERT_NEXT(a_heading_add, s_fire && (in_kind == KIND_ROTATE), heading_q == $past(heading_q + in_ang), "rotate transaction did not advance the heading")
  `QCR_ASSERT_NEXT(a_set_stays_idle, s_fire && (in_kind == KIND_SET), state_q == ST_IDLE, "set transaction started a rotation run")
  `QCR_ASSERT(a_last_marks_corner3, m_valid_q |-> (m_last_q == (m_corner_q == LastCorner)), "tlast does not match the final corner")
  `QCR_ASSERT_NEXT(a_emit_loads_output, (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready), m_valid_q && (m_corner_q == $past(corner_q)), "emitted corner not presented on the output")

endmodule

// ===== tb/corner_rotation_checker.sv =====
// Checker for the quad corner rotator: mirrors the corner registers and heading,
// predicts every rotated corner with a fixed-point CORDIC and compares results.
// Depends on qcr_pkg for the register index width, the transaction kinds and the last corner.
`timescale 1ns / 1ps

module corner_rotation_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [qcr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                 cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [47:0]                 in_data_i,    // pivot_x, pivot_y, angle_value
  input  logic [0:0]                  in_kind_i,    // kind
  // output channel
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [47:0]                 out_data_i,   // rotated_x, rotated_y, heading_now
  input  logic [1:0]                  out_corner_i, // corner_index
  input  logic                        out_last_i,   // last_corner
  output int                          pending_o,
  output int                          fail_count_o
);

  localparam int Steps      = 16;
  localparam int MaxReports = 60;

  typedef struct packed {
    logic [1:0]  corner;
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic [15:0] heading;
  } corner_result_t;

  corner_result_t expected_corners_q [$];
  logic [15:0]    corner_regs [8];
  logic [15:0]    heading_q;

  // arctangent of 2^-i, 2^32 units per turn
  function automatic longint atan_step(input int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      default: return 0;
    endcase
  endfunction

  // floor square root, one result bit at a time from the top
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // inverse CORDIC gain in Q30
  function automatic longint unsigned inverse_gain_q30();
    longint unsigned p;
    p = 64'd1 << 30;
    for (int i = 0; i < Steps; i++) p = p + (p >> (2 * i));
    return (64'd1 << 60) / int_sqrt(p << 30);
  endfunction

  // Q16 value times Q30 gain, rounded half away from zero to an integer
  function automatic longint scale_by_gain(input longint v, input longint unsigned k);
    longint unsigned mag;
    longint unsigned t;
    logic            neg;
    neg = v < 0;
    mag = neg ? longint'(-v) : v;
    t   = (mag >> 16) * k + (((mag & 64'hFFFF) * k) >> 16);
    t   = (t + (64'd1 << 29)) >> 30;
    return neg ? -longint'(t) : longint'(t);
  endfunction

  function automatic logic [15:0] clamp_coord(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // rotate one corner counterclockwise about the pivot by the heading
  function automatic void rotate_corner(input logic [15:0] cx, input logic [15:0] cy,
                                        input logic [15:0] px, input logic [15:0] py,
                                        input logic [15:0] hdg,
                                        output logic [15:0] rx, output logic [15:0] ry);
    longint dx, dy, a, x, y, z, xn;
    longint unsigned k;
    dx = longint'($signed(cx)) - longint'($signed(px));
    dy = longint'($signed(cy)) - longint'($signed(py));
    a  = longint'($signed(hdg));
    // fold the angle into the half plane the CORDIC converges on
    if (a > 16384) begin
      dx = -dx;
      dy = -dy;
      a  = a - 32768;
    end else if (a < -16384) begin
      dx = -dx;
      dy = -dy;
      a  = a + 32768;
    end
    x = dx * 65536;
    y = dy * 65536;
    z = a * 65536;
    for (int i = 0; i < Steps; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_step(i);
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_step(i);
      end
      x = xn;
    end
    k  = inverse_gain_q30();
    rx = clamp_coord(scale_by_gain(x, k) + longint'($signed(px)));
    ry = clamp_coord(scale_by_gain(y, k) + longint'($signed(py)));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count_o < MaxReports)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    fail_count_o = fail_count_o + 1;
  endtask

  // track configuration, predict on input transactions, check output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    corner_result_t want;
    logic [15:0]    rx;
    logic [15:0]    ry;
    if (!rst_ni) begin
      for (int r = 0; r < 8; r++) corner_regs[r] = '0;
      heading_q = '0;
      expected_corners_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) corner_regs[cfg_idx_i] = cfg_data_i;

      if (out_valid_i && out_ready_i) begin
        if (expected_corners_q.size() == 0) begin
          report_mismatch("unexpected corner, index", out_corner_i, -1);
        end else begin
          want = expected_corners_q.pop_front();
          if (out_corner_i !== want.corner)
            report_mismatch("corner_index", out_corner_i, want.corner);
          if (out_data_i[15:0] !== want.x)
            report_mismatch("rotated_x", $signed(out_data_i[15:0]), $signed(want.x));
          if (out_data_i[31:16] !== want.y)
            report_mismatch("rotated_y", $signed(out_data_i[31:16]), $signed(want.y));
          if (out_last_i !== want.last)
            report_mismatch("last_corner", out_last_i, want.last);
          if (out_data_i[47:32] !== want.heading)
            report_mismatch("heading_now", out_data_i[47:32], want.heading);
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (in_kind_i[0] == qcr_pkg::KIND_SET) begin
          heading_q = in_data_i[47:32];
        end else begin
          heading_q = heading_q + in_data_i[47:32];
          for (int c = 0; c < 4; c++) begin
            rotate_corner(corner_regs[2 * c], corner_regs[2 * c + 1],
                          in_data_i[15:0], in_data_i[31:16], heading_q, rx, ry);
            want.corner  = 2'(c);
            want.x       = rx;
            want.y       = ry;
            want.last    = (2'(c) == qcr_pkg::LastCorner);
            want.heading = heading_q;
            expected_corners_q.push_back(want);
          end
        end
      end

      pending_o = expected_corners_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the quad corner rotator testbench: clock, reset, stimulus and verdict.
// Depends on qcr_pkg, quad_corner_rotator_unit and corner_rotation_checker.
`timescale 1ns / 1ps

module testbench;
  import qcr_pkg::*;

  localparam int DataW          = 48;
  localparam int DrainCycles    = 130;
  localparam int WatchdogLimit  = 3000;
  localparam int PhaseItems     = 58;
  localparam int CfgFullRandom  = 0;
  localparam int CfgSmall       = 1;
  localparam int CfgExtreme     = 2;
  localparam int CfgMixed       = 3;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [DataW-1:0]   s_axis_tdata;   // pivot_x, pivot_y, angle_value
  logic [0:0]         s_axis_tuser;   // kind
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [DataW-1:0]   m_axis_tdata;   // rotated_x, rotated_y, heading_now
  logic [CornerW-1:0] m_axis_tuser;   // corner_index
  logic               m_axis_tlast;   // last_corner

  int pending;
  int fail_count;
  int idle_cycles;
  bit src_idle_on;
  bit snk_idle_on;

  quad_corner_rotator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  corner_rotation_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_corner_i(m_axis_tuser),
    .out_last_i  (m_axis_tlast),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // stop the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stall before each output transaction
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = snk_idle_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4:    return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 15))
      0:       return 16'h4000;
      1:       return 16'h4001;
      2:       return 16'hC000;
      3:       return 16'hBFFF;
      4:       return 16'h8000;
      5:       return 16'h7FFF;
      6:       return 16'h0000;
      7:       return 16'hFFFF;
      8, 9:    return 16'($urandom_range(0, 63)) - 16'd32;
      default: return 16'($urandom());
    endcase
  endfunction

  // one input transaction, after a random gap
  task automatic send_item(input logic kind, input logic [15:0] px, input logic [15:0] py,
                           input logic [15:0] angle);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {angle, py, px};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic send_random_item();
    logic kind;
    kind = ($urandom_range(0, 3) == 0) ? KIND_SET : KIND_ROTATE;
    send_item(kind, pick_coord(), pick_coord(), pick_angle());
  endtask

  // hold off until every predicted corner is out and the block has settled
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_corner_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_corners(input int pattern);
    logic [15:0] value;
    for (int r = 0; r < 8; r++) begin
      case (pattern)
        CfgFullRandom: value = 16'($urandom());
        CfgSmall:      value = 16'($urandom_range(0, 511)) - 16'd256;
        CfgExtreme:    value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default:       value = pick_coord();
      endcase
      write_corner_reg(REG_CORNER0_X + CfgIdxW'(r), value);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_SET;
    src_idle_on   = 1'b1;
    snk_idle_on   = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // square of side 200 about the origin
    write_corner_reg(REG_CORNER0_X, 16'd100);
    write_corner_reg(REG_CORNER0_Y, 16'd100);
    write_corner_reg(REG_CORNER1_X, -16'sd100);
    write_corner_reg(REG_CORNER1_Y, 16'd100);
    write_corner_reg(REG_CORNER2_X, -16'sd100);
    write_corner_reg(REG_CORNER2_Y, -16'sd100);
    write_corner_reg(REG_CORNER3_X, 16'd100);
    write_corner_reg(REG_CORNER3_Y, -16'sd100);
    cfg_we_i <= 1'b0;

    // zero heading, quarter-turn boundaries, half turn, heading wrap
    send_item(KIND_ROTATE, 16'h0000, 16'h0000, 16'h0000);
    send_item(KIND_SET,    16'h0000, 16'h0000, 16'h4000);
    send_item(KIND_ROTATE, 16'h0000, 16'h0000, 16'h0000);
    send_item(KIND_ROTATE, 16'h0000, 16'h0000, 16'h0001);
    send_item(KIND_SET,    16'h0000, 16'h0000, 16'hC000);
    send_item(KIND_ROTATE, 16'h0000, 16'h0000, 16'h0000);
    send_item(KIND_ROTATE, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(KIND_SET,    16'h0000, 16'h0000, 16'h8000);
    send_item(KIND_ROTATE, 16'h0000, 16'h0000, 16'h0000);
    send_item(KIND_SET,    16'h0000, 16'h0000, 16'h7FFF);
    send_item(KIND_ROTATE, 16'h0000, 16'h0000, 16'h7FFF);
    // pivots at the coordinate limits push results into saturation
    send_item(KIND_ROTATE, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_item(KIND_ROTATE, 16'h8000, 16'h8000, 16'h2000);
    send_item(KIND_ROTATE, 16'h1234, 16'hEDCB, 16'h1555);

    // corners at the coordinate limits
    wait_quiet();
    write_corner_reg(REG_CORNER0_X, 16'h7FFF);
    write_corner_reg(REG_CORNER0_Y, 16'h7FFF);
    write_corner_reg(REG_CORNER1_X, 16'h8000);
    write_corner_reg(REG_CORNER1_Y, 16'h8000);
    write_corner_reg(REG_CORNER2_X, 16'h7FFF);
    write_corner_reg(REG_CORNER2_Y, 16'h8000);
    write_corner_reg(REG_CORNER3_X, 16'h8000);
    write_corner_reg(REG_CORNER3_Y, 16'h7FFF);
    cfg_we_i <= 1'b0;
    send_item(KIND_SET,    16'h5555, 16'hAAAA, 16'h0000);
    send_item(KIND_ROTATE, 16'h0000, 16'h0000, 16'h2000);
    send_item(KIND_ROTATE, 16'h8000, 16'h7FFF, 16'h4000);
    send_item(KIND_ROTATE, 16'h7FFF, 16'h8000, 16'h2000);
    send_item(KIND_ROTATE, 16'hFFFF, 16'h0001, 16'h4000);
    send_item(KIND_ROTATE, 16'h0000, 16'h0000, 16'hE000);

    // random phases, each with its own corner set and idling mix
    for (int p = 0; p < 6; p++) begin
      wait_quiet();
      load_corners(p % 4);
      src_idle_on = (p != 1) && (p != 3);
      snk_idle_on = (p != 2) && (p != 3);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 39) == 0) wait_quiet();
        send_random_item();
      end
    end

    wait_quiet();
    @(negedge clk_i);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
